// ===== hw/rtl/mteq_pkg.sv =====
package mteq_pkg;

  // Number of timer slots and the widths that follow from it.
  localparam int unsigned TIMER_SLOTS = 16;
  localparam int unsigned SLOT_W      = $clog2(TIMER_SLOTS);
  localparam int unsigned CNT_W       = $clog2(TIMER_SLOTS + 1);

  // Field widths of the stream items.
  localparam int unsigned MS_W     = 32;
  localparam int unsigned TARGET_W = 8;
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned KIND_W   = 2;

  localparam int unsigned IN_DATA_W  = 88;
  localparam int unsigned OUT_DATA_W = 32;

  // Input item kinds; the remaining code is ignored by the block.
  typedef enum logic [KIND_W-1:0] {
    KIND_TICK   = 2'd0,
    KIND_ADD    = 2'd1,
    KIND_CANCEL = 2'd2
  } kind_e;

  // One input item as captured at the transfer.
  typedef struct packed {
    kind_e                kind;
    logic [MS_W-1:0]      elapsed_ms;
    logic [MS_W-1:0]      delay_ms;
    logic [TARGET_W-1:0]  target_id;
    logic [TAG_W-1:0]     action_tag;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic                 fired;
    logic [TARGET_W-1:0]  fired_target;
    logic [TAG_W-1:0]     fired_tag;
    logic                 last;
    logic                 busy_res;
    logic                 overflow;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the input item and clear the walk state
    logic deduct;    // subtract elapsed time from the slot under the walk index
    logic scan;      // compare the slot under the walk index against the best so far
    logic fire;      // retire the best expired slot
    logic cancel;    // drop the slot under the walk index if its target matches
    logic store;     // write the new timer into the free slot
    logic sel_best;  // read the slot arrays at the best index, present a fired result
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    kind_e kind;
    logic  delay_zero;
    logic  walk_last;
    logic  exp_none;
    logic  exp_one;
    logic  free_found;
  } dp_sts_t;

endpackage

// ===== hw/rtl/multi_timer_expiry_queue.sv =====
// Table of one-shot timers. Each input transfer is a tick, an add or a cancel,
// and every input yields one or more result transfers, the final one marked by
// m_axis_tlast. A tick or an add with a nonzero delay walks all slots once to
// deduct the elapsed time (one slot per cycle), then finds each expired timer
// by its own further walk over all slots; a cancel walks all slots once, and
// a zero-delay add or an unused kind walks none. Each result also waits for
// the output register to free up. All walks use the single slot-table read
// port, stepped by one walk counter. One item is processed at a time; the
// output register lets the block accept the next input while the final result
// still waits downstream.
module multi_timer_expiry_queue
  import mteq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // elapsed_ms[31:0], delay_ms[63:32], target_id[71:64], action_tag[87:72]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // kind[1:0]
  input  logic [KIND_W-1:0]     s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // fired_target[7:0], fired_tag[23:8], busy_res[24], overflow[25], zero[31:26]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // fired[0]
  output logic [0:0]            m_axis_tuser,
  output logic                  m_axis_tlast
);

  in_item_t item;
  dp_cmd_t  cmd;
  dp_sts_t  sts;
  res_t     res;
  logic     emit;
  logic     out_free;
  logic     out_valid_q;
  res_t     out_q;

  // Unpack the input transfer.
  assign item.kind       = kind_e'(s_axis_tuser);
  assign item.elapsed_ms = s_axis_tdata[31:0];
  assign item.delay_ms   = s_axis_tdata[63:32];
  assign item.target_id  = s_axis_tdata[71:64];
  assign item.action_tag = s_axis_tdata[87:72];

  mteq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .emit_o     (emit),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mteq_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .res_o  (res)
  );

  // Output register: free when empty or when its result is taken this cycle.
  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res;
    end
  end

  // Pack the result transfer.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q.overflow, out_q.busy_res, out_q.fired_tag,
                          out_q.fired_target};
  assign m_axis_tuser  = out_q.fired;
  assign m_axis_tlast  = out_q.last;

endmodule

// ===== hw/rtl/mteq_dp.sv =====
module mteq_dp
  import mteq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_item_t item_i,
  input  dp_cmd_t  cmd_i,
  output dp_sts_t  sts_o,
  output res_t     res_o
);

  // Captured input item.
  in_item_t item_q;

  // Slot table: valid and expired flags reset, contents written before use.
  logic [TIMER_SLOTS-1:0] valid_q;
  logic [TIMER_SLOTS-1:0] exp_q;
  logic [MS_W-1:0]        rem_q [TIMER_SLOTS];
  logic [TARGET_W-1:0]    tgt_q [TIMER_SLOTS];
  logic [TAG_W-1:0]       tag_q [TIMER_SLOTS];

  // Counters and walk state.
  logic [CNT_W-1:0]  live_cnt_q;
  logic [CNT_W-1:0]  exp_cnt_q;
  logic [SLOT_W-1:0] walk_q;
  logic [SLOT_W-1:0] best_q;
  logic [MS_W-1:0]   best_rem_q;
  logic              best_found_q;
  logic [SLOT_W-1:0] free_q;
  logic              free_found_q;

  logic [SLOT_W-1:0]   rd_idx;
  logic [MS_W-1:0]     rd_rem;
  logic [TARGET_W-1:0] rd_tgt;
  logic [TAG_W-1:0]    rd_tag;
  logic                rd_valid;
  logic                expires;
  logic                walk_last;
  logic                add_timer;
  logic                imm_fire;
  logic                busy;
  logic                ovf;

  // Slot read port, shared by the walk and by the retire of the best slot.
  assign rd_idx   = cmd_i.sel_best ? best_q : walk_q;
  assign rd_rem   = rem_q[rd_idx];
  assign rd_tgt   = tgt_q[rd_idx];
  assign rd_tag   = tag_q[rd_idx];
  assign rd_valid = valid_q[rd_idx];
  assign expires  = item_q.elapsed_ms >= rd_rem;

  assign walk_last = walk_q == SLOT_W'(TIMER_SLOTS - 1);

  // Summary flags that hold on every result of the current item.
  assign add_timer = (item_q.kind == KIND_ADD) && (item_q.delay_ms != '0);
  assign imm_fire  = (item_q.kind == KIND_ADD) && (item_q.delay_ms == '0);
  assign busy      = (live_cnt_q != exp_cnt_q) || add_timer;
  assign ovf       = add_timer && (live_cnt_q == CNT_W'(TIMER_SLOTS)) && (exp_cnt_q == '0);

  // Result payload: either the best expired slot or the single plain result.
  always_comb begin
    res_o.busy_res = busy;
    res_o.overflow = ovf;
    if (cmd_i.sel_best) begin
      res_o.fired        = 1'b1;
      res_o.fired_target = rd_tgt;
      res_o.fired_tag    = rd_tag;
      res_o.last         = exp_cnt_q == CNT_W'(1);
    end else begin
      res_o.fired        = imm_fire;
      res_o.fired_target = imm_fire ? item_q.target_id : '0;
      res_o.fired_tag    = imm_fire ? item_q.action_tag : '0;
      res_o.last         = 1'b1;
    end
  end

  assign sts_o.kind       = item_q.kind;
  assign sts_o.delay_zero = item_q.delay_ms == '0;
  assign sts_o.walk_last  = walk_last;
  assign sts_o.exp_none   = exp_cnt_q == '0;
  assign sts_o.exp_one    = exp_cnt_q == CNT_W'(1);
  assign sts_o.free_found = free_found_q;

  // Input capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
  end

  // Slot contents: deduction at the walk index, new timer at the free slot.
  always_ff @(posedge clk_i) begin
    if (cmd_i.deduct && rd_valid && !expires) begin
      rem_q[walk_q] <= rd_rem - item_q.elapsed_ms;
    end
    if (cmd_i.store) begin
      rem_q[free_q] <= item_q.delay_ms;
      tgt_q[free_q] <= item_q.target_id;
      tag_q[free_q] <= item_q.action_tag;
    end
  end

  // Flags, counters and walk state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      exp_q        <= '0;
      live_cnt_q   <= '0;
      exp_cnt_q    <= '0;
      walk_q       <= '0;
      best_q       <= '0;
      best_rem_q   <= '0;
      best_found_q <= 1'b0;
      free_q       <= '0;
      free_found_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        exp_q        <= '0;
        exp_cnt_q    <= '0;
        walk_q       <= '0;
        best_found_q <= 1'b0;
        free_found_q <= 1'b0;
      end

      // Walk index steps with every per-slot command and wraps after the last slot.
      if (cmd_i.deduct || cmd_i.scan || cmd_i.cancel) begin
        walk_q <= walk_last ? '0 : walk_q + SLOT_W'(1);
      end

      // Expiry check; the first free or expiring slot takes a new timer later.
      if (cmd_i.deduct) begin
        if (rd_valid && expires) begin
          exp_q[walk_q] <= 1'b1;
          exp_cnt_q     <= exp_cnt_q + CNT_W'(1);
        end
        if (!free_found_q && (!rd_valid || expires)) begin
          free_q       <= walk_q;
          free_found_q <= 1'b1;
        end
      end

      // Minimum search over expired slots; strict compare keeps the lowest slot on ties.
      if (cmd_i.scan && exp_q[walk_q] && (!best_found_q || rd_rem < best_rem_q)) begin
        best_q       <= walk_q;
        best_rem_q   <= rd_rem;
        best_found_q <= 1'b1;
      end

      // Retire the slot just reported.
      if (cmd_i.fire) begin
        valid_q[best_q] <= 1'b0;
        exp_q[best_q]   <= 1'b0;
        exp_cnt_q       <= exp_cnt_q - CNT_W'(1);
        live_cnt_q      <= live_cnt_q - CNT_W'(1);
        best_found_q    <= 1'b0;
      end

      if (cmd_i.cancel && rd_valid && (rd_tgt == item_q.target_id)) begin
        valid_q[walk_q] <= 1'b0;
        live_cnt_q      <= live_cnt_q - CNT_W'(1);
      end

      if (cmd_i.store) begin
        valid_q[free_q] <= 1'b1;
        live_cnt_q      <= live_cnt_q + CNT_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/mteq_ctrl.sv =====
module mteq_ctrl
  import mteq_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  logic    out_free_i,
  output logic    emit_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_DEDUCT,
    ST_CHECK,
    ST_SCAN,
    ST_FIRE,
    ST_PLAIN,
    ST_STORE
  } state_e;

  state_e state_q, state_d;
  logic   cancel_walk_q, cancel_walk_d;

  // Command decode and next state.
  always_comb begin
    state_d       = state_q;
    cancel_walk_d = cancel_walk_q;
    cmd_o         = '0;
    emit_o        = 1'b0;
    in_ready_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (sts_i.kind)
          KIND_TICK: begin
            state_d = ST_DEDUCT;
          end
          KIND_ADD: begin
            state_d = sts_i.delay_zero ? ST_PLAIN : ST_DEDUCT;
          end
          KIND_CANCEL: begin
            cancel_walk_d = 1'b1;
            state_d       = ST_DEDUCT;
          end
          default: begin
            state_d = ST_PLAIN;
          end
        endcase
      end
      ST_DEDUCT: begin
        // The same walk serves the deduction and the cancel sweep.
        cmd_o.deduct = !cancel_walk_q;
        cmd_o.cancel = cancel_walk_q;
        if (sts_i.walk_last) begin
          cancel_walk_d = 1'b0;
          state_d       = cancel_walk_q ? ST_PLAIN : ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_d = sts_i.exp_none ? ST_PLAIN : ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.walk_last) begin
          state_d = ST_FIRE;
        end
      end
      ST_FIRE: begin
        cmd_o.sel_best = 1'b1;
        if (out_free_i) begin
          emit_o     = 1'b1;
          cmd_o.fire = 1'b1;
          state_d    = sts_i.exp_one ? ST_STORE : ST_SCAN;
        end
      end
      ST_PLAIN: begin
        if (out_free_i) begin
          emit_o  = 1'b1;
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        // A full table with nothing expired leaves no free slot, and the add is dropped.
        cmd_o.store = (sts_i.kind == KIND_ADD) && !sts_i.delay_zero && sts_i.free_found;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cancel_walk_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      cancel_walk_q <= cancel_walk_d;
    end
  end

endmodule

// ===== dv/expiry_check_pkg.sv =====
package expiry_check_pkg;
  import mteq_pkg::*;

  // Tracks the timer table as the block should hold it and keeps the results
  // that are still due from the output stream.
  class expiry_scoreboard;
    bit                  slot_live   [TIMER_SLOTS];
    logic [MS_W-1:0]     slot_left   [TIMER_SLOTS];
    logic [TARGET_W-1:0] slot_target [TIMER_SLOTS];
    logic [TAG_W-1:0]    slot_tag    [TIMER_SLOTS];
    res_t                expiry_q[$];

    int unsigned mismatches;
    int unsigned requests_seen;
    int unsigned results_seen;
    int unsigned timers_fired;
    int unsigned dropped_adds;
    int unsigned full_bursts;
    int unsigned cancel_hits;

    function new();
      foreach (slot_live[i]) begin
        slot_live[i] = 1'b0;
      end
    endfunction

    function int unsigned pending();
      return expiry_q.size();
    endfunction

    function int unsigned live_timers();
      int unsigned n;
      n = 0;
      foreach (slot_live[i]) begin
        if (slot_live[i]) begin
          n++;
        end
      end
      return n;
    endfunction

    function res_t fired_result(logic [TARGET_W-1:0] target, logic [TAG_W-1:0] tag);
      res_t r;
      r = '0;
      r.fired        = 1'b1;
      r.fired_target = target;
      r.fired_tag    = tag;
      return r;
    endfunction

    // Applies one accepted request to the table and queues the results it causes.
    function void note_request(logic [KIND_W-1:0] kind, logic [MS_W-1:0] elapsed,
                               logic [MS_W-1:0] delay, logic [TARGET_W-1:0] target,
                               logic [TAG_W-1:0] tag);
      res_t burst[$];
      res_t r;
      bit   expired [TIMER_SLOTS];
      int   best;
      int   free_slot;
      bit   dropped;
      bit   busy;
      dropped = 1'b0;
      requests_seen++;
      if (kind == KIND_ADD && delay == '0) begin
        // A zero-delay timer fires at once and never touches the table.
        burst.push_back(fired_result(target, tag));
      end else if (kind == KIND_TICK || kind == KIND_ADD) begin
        // Deduct the elapsed time; a timer expires once its time is used up.
        foreach (expired[i]) begin
          expired[i] = 1'b0;
          if (slot_live[i]) begin
            if (elapsed >= slot_left[i]) begin
              expired[i] = 1'b1;
            end else begin
              slot_left[i] = slot_left[i] - elapsed;
            end
          end
        end
        // Fire the expired timers, shortest remaining time first, ties to the lowest slot.
        forever begin
          best = -1;
          foreach (expired[i]) begin
            if (expired[i] && (best < 0 || slot_left[i] < slot_left[best])) begin
              best = i;
            end
          end
          if (best < 0) begin
            break;
          end
          expired[best]  = 1'b0;
          slot_live[best] = 1'b0;
          burst.push_back(fired_result(slot_target[best], slot_tag[best]));
        end
        // An add then takes the lowest free slot, or is dropped on a full table.
        if (kind == KIND_ADD) begin
          free_slot = -1;
          foreach (slot_live[i]) begin
            if (!slot_live[i] && free_slot < 0) begin
              free_slot = i;
            end
          end
          if (free_slot >= 0) begin
            slot_live[free_slot]   = 1'b1;
            slot_left[free_slot]   = delay;
            slot_target[free_slot] = target;
            slot_tag[free_slot]    = tag;
          end else begin
            dropped = 1'b1;
          end
        end
      end else if (kind == KIND_CANCEL) begin
        foreach (slot_live[i]) begin
          if (slot_live[i] && slot_target[i] == target) begin
            slot_live[i] = 1'b0;
            cancel_hits++;
          end
        end
      end
      if (burst.size() == 0) begin
        burst.push_back('0);
      end
      busy = (live_timers() != 0);
      foreach (burst[k]) begin
        r          = burst[k];
        r.last     = (k == burst.size() - 1);
        r.busy_res = busy;
        r.overflow = dropped;
        expiry_q.push_back(r);
      end
      if (dropped) begin
        dropped_adds++;
      end
      if (burst.size() == TIMER_SLOTS) begin
        full_bursts++;
      end
    endfunction

    task report(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Compares one result transfer with the oldest result still due.
    task check_expiry(res_t got);
      res_t want;
      if (expiry_q.size() == 0) begin
        report($sformatf("result with nothing due: fired=%0b target=%02h tag=%04h",
                         got.fired, got.fired_target, got.fired_tag));
        return;
      end
      want = expiry_q.pop_front();
      results_seen++;
      if (got.fired) begin
        timers_fired++;
      end
      if (got.fired !== want.fired) begin
        report($sformatf("result %0d fired %0b, want %0b", results_seen, got.fired,
                         want.fired));
      end
      if (got.fired_target !== want.fired_target) begin
        report($sformatf("result %0d target %02h, want %02h", results_seen,
                         got.fired_target, want.fired_target));
      end
      if (got.fired_tag !== want.fired_tag) begin
        report($sformatf("result %0d tag %04h, want %04h", results_seen, got.fired_tag,
                         want.fired_tag));
      end
      if (got.last !== want.last) begin
        report($sformatf("result %0d last %0b, want %0b", results_seen, got.last,
                         want.last));
      end
      if (got.busy_res !== want.busy_res) begin
        report($sformatf("result %0d busy %0b, want %0b", results_seen, got.busy_res,
                         want.busy_res));
      end
      if (got.overflow !== want.overflow) begin
        report($sformatf("result %0d overflow %0b, want %0b", results_seen,
                         got.overflow, want.overflow));
      end
    endtask

    task flag_leftovers();
      while (expiry_q.size() != 0) begin
        void'(expiry_q.pop_front());
        report("result still due at the end of the run");
      end
    endtask
  endclass

endpackage

// ===== dv/testbench.sv =====
module testbench;
  import mteq_pkg::*;
  import expiry_check_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 10;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int PHASE_ITEMS  = 114;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [KIND_W-1:0]     s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]            m_axis_tuser;
  logic                  m_axis_tlast;

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned cycles    = 0;

  expiry_scoreboard sb = new();

  multi_timer_expiry_queue uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Random backpressure on the result stream.
  always @(negedge clk_i) begin
    m_axis_tready = ($urandom_range(99) >= stall_pct);
  end

  // Every result transfer is unpacked and checked in order.
  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got              = '0;
      got.fired        = m_axis_tuser[0];
      got.fired_target = m_axis_tdata[7:0];
      got.fired_tag    = m_axis_tdata[23:8];
      got.busy_res     = m_axis_tdata[24];
      got.overflow     = m_axis_tdata[25];
      got.last         = m_axis_tlast;
      sb.check_expiry(got);
    end
  end

  // Hard stop if the run hangs.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results due", cycles, sb.pending());
      $display("tb: failure");
      $finish;
    end
  end

  // Offers one request, with random idle cycles first, and waits for its transfer.
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [MS_W-1:0] elapsed,
                           input logic [MS_W-1:0] delay, input logic [TARGET_W-1:0] target,
                           input logic [TAG_W-1:0] tag);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {tag, target, delay, elapsed};
    s_axis_tuser  = kind;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    sb.note_request(kind, elapsed, delay, target, tag);
    @(negedge clk_i);
  endtask

  // Holds the sender back until every result due has arrived.
  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Mostly adds and short ticks so the table churns, fills up and overflows;
  // the occasional huge elapsed time flushes it in one burst.
  task automatic random_item();
    logic [KIND_W-1:0]   kind;
    logic [MS_W-1:0]     elapsed;
    logic [MS_W-1:0]     delay;
    logic [TARGET_W-1:0] target;
    logic [TAG_W-1:0]    tag;
    int unsigned         pick;
    pick = $urandom_range(99);
    if (pick < 48) begin
      kind = KIND_ADD;
    end else if (pick < 53) begin
      kind = KIND_ADD;
    end else if (pick < 80) begin
      kind = KIND_TICK;
    end else if (pick < 95) begin
      kind = KIND_CANCEL;
    end else begin
      kind = KIND_UNUSED;
    end
    case ($urandom_range(99)) inside
      [0:39]:  elapsed = '0;
      [40:79]: elapsed = $urandom_range(60);
      [80:91]: elapsed = $urandom_range(1000);
      [92:96]: elapsed = $urandom;
      default: elapsed = '1;
    endcase
    case ($urandom_range(99)) inside
      [0:14]:  delay = $urandom_range(5, 1);
      [15:84]: delay = $urandom_range(300, 1);
      default: delay = $urandom;
    endcase
    if (pick >= 48 && pick < 53) begin
      delay = '0;
    end
    target = 8'(($urandom_range(99) < 70) ? $urandom_range(7) : $urandom_range(255));
    tag    = 16'($urandom_range(65535));
    send_item(kind, elapsed, delay, target, tag);
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty tick, ignored kind, a zero-delay add, exact expiry and
    // ties, an add that fires first, cancels, a full table and a full flush.
    send_item(KIND_TICK, '0, '0, '0, '0);
    send_item(KIND_UNUSED, '1, '1, '1, '1);
    send_item(KIND_ADD, '1, '0, 8'hFF, 16'hFFFF);
    send_item(KIND_ADD, '0, '1, 8'hAA, 16'h5555);
    send_item(KIND_ADD, '0, 32'd1, 8'h01, 16'h0001);
    send_item(KIND_ADD, '0, 32'd1, 8'h02, 16'h0002);
    send_item(KIND_ADD, '0, 32'd5, 8'h03, 16'h0003);
    send_item(KIND_TICK, 32'd1, '0, '0, '0);
    send_item(KIND_ADD, 32'd4, 32'd3, 8'h10, 16'h0A0A);
    send_item(KIND_CANCEL, '1, '1, 8'hAA, '1);
    send_item(KIND_CANCEL, '0, '0, 8'h77, '0);
    for (int n = 0; n < TIMER_SLOTS - 1; n++) begin
      send_item(KIND_ADD, '0, 32'(200 - 10 * (n % 5)), 8'(n + 32), 16'(16'h1000 + n));
    end
    send_item(KIND_ADD, '0, 32'd42, 8'h55, 16'hAAAA);
    send_item(KIND_TICK, '1, '0, '0, '0);
    drain();

    // Random requests under four idling regimes, drained between regimes.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 81; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 81; end
        default: begin idle_pct = 21; stall_pct = 21; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_item();
      end
      drain();
    end

    repeat (4 * TIMER_SLOTS + 20) @(negedge clk_i);
    sb.flag_leftovers();
    $display("summary: %0d requests, %0d results, %0d timers fired, %0d cancelled",
             sb.requests_seen, sb.results_seen, sb.timers_fired, sb.cancel_hits);
    $display("summary: %0d adds dropped on a full table, %0d bursts of %0d results",
             sb.dropped_adds, sb.full_bursts, TIMER_SLOTS);
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
